// ===== rtl/rsn_pkg.sv =====
// Shared constants and helper functions for the ray against sphere table core.
package rsn_pkg;

  localparam int MAX_SPHERES = 16;
  localparam int SLOT_W      = 4;
  localparam int COUNT_W     = 5;
  localparam int ENT_W       = 127;

  localparam int OP_W   = 44;
  localparam int PROD_W = 88;
  localparam int DIG_W  = 11;
  localparam int DIG_N  = 4;
  localparam int DCNT_W = 2;

  localparam int RAD_W  = 88;
  localparam int ROOT_W = 44;
  localparam int QUO_W  = 17;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_MIND  = 1'b1;

  localparam logic [15:0] MIN_DIST_RST = 16'd66;

  function automatic logic [OP_W-1:0] mag(input logic signed [OP_W-1:0] x);
    return x[OP_W-1] ? OP_W'(-x) : OP_W'(x);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -42'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/rsn_ram.sv =====
// Generic single-port-write RAM with registered read.
module rsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rsn_mul.sv =====
// Shared unsigned multiplier, one 11-bit digit of the second operand per cycle.
module rsn_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsn_pkg::OP_W-1:0]   a,
  input  logic [rsn_pkg::OP_W-1:0]   b,
  output logic                       done,
  output logic [rsn_pkg::PROD_W-1:0] prod
);

  logic                                      run;
  logic [rsn_pkg::DCNT_W-1:0]                cnt;
  logic [rsn_pkg::OP_W-1:0]                  ar;
  logic [rsn_pkg::OP_W-1:0]                  br;
  logic [rsn_pkg::PROD_W-1:0]                acc;
  logic [rsn_pkg::OP_W+rsn_pkg::DIG_W-1:0]   part;

  assign part = ar * br[rsn_pkg::DIG_W*cnt +: rsn_pkg::DIG_W];
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ar  <= a;
        br  <= b;
        acc <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        acc <= acc + (rsn_pkg::PROD_W'(part) << (rsn_pkg::DIG_W * cnt));
        cnt <= cnt + 1'b1;
        if (cnt == rsn_pkg::DCNT_W'(rsn_pkg::DIG_N - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rsn_sqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
module rsn_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsn_pkg::RAD_W-1:0]  rad,
  output logic                       done,
  output logic [rsn_pkg::ROOT_W-1:0] root
);

  logic                              run;
  logic [5:0]                        cnt;
  logic [rsn_pkg::RAD_W-1:0]         nsh;
  logic [rsn_pkg::ROOT_W+2:0]        rem;
  logic [rsn_pkg::ROOT_W+2:0]        shifted;
  logic [rsn_pkg::ROOT_W+2:0]        trial;
  logic                              ge;

  assign shifted = {rem[rsn_pkg::ROOT_W:0], nsh[rsn_pkg::RAD_W-1 -: 2]};
  assign trial   = {1'b0, root, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh  <= rad;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        run  <= 1'b1;
      end else if (run) begin
        nsh  <= nsh << 2;
        rem  <= ge ? shifted - trial : shifted;
        root <= {root[rsn_pkg::ROOT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == 6'(rsn_pkg::ROOT_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rsn_div.sv =====
// Restoring divider for num * 2^16 / den with num not above den.
module rsn_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rsn_pkg::OP_W-1:0]   num,
  input  logic [rsn_pkg::ROOT_W-1:0] den,
  output logic                       done,
  output logic [rsn_pkg::QUO_W-1:0]  quo
);

  logic                              run;
  logic [4:0]                        cnt;
  logic [rsn_pkg::ROOT_W:0]          rem;
  logic [rsn_pkg::ROOT_W:0]          tmp;
  logic                              ge;

  // first step compares the plain numerator, later ones the doubled remainder
  assign tmp = (cnt == '0) ? rem : {rem[rsn_pkg::ROOT_W-1:0], 1'b0};
  assign ge  = tmp >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= (rsn_pkg::ROOT_W+1)'(num);
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? tmp - {1'b0, den} : tmp;
        quo <= {quo[rsn_pkg::QUO_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == 5'(rsn_pkg::QUO_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ray_sphere_nearest_hit_core.sv =====
// Ray against sphere table nearest-hit core: sequencer, table and shared units.
//
// Usage: a transfer on the command channel is taken when start is high and busy
// is low. opcode 0 writes a sphere slot (centre in pos_*, radius) in that one
// cycle and gives no result; busy stays low. opcode 1 casts a ray (origin in
// pos_*, unit direction in dir_*) and raises busy until the result is out.
// Each active slot takes eight products on the shared 44x11 digit multiplier
// and, unless its discriminant is negative, a 44-step square root. After the
// walk, a hit goes on to the point, the normal length and three 17-step
// divisions. The result appears for exactly one cycle with done high, in the
// cycle that busy falls; the receiver cannot stall it, so it must take it
// then. A miss returns all fields zero.
// Registers on the APB port: sphere_count at 0x0, min_distance at 0x4; write
// them only while busy is low. Reset sets sphere_count to 0, min_distance to
// 66 and returns the sequencer to idle; the sphere table is not cleared and a
// slot must be loaded before a cast uses it.
module ray_sphere_nearest_hit_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               opcode,
  input  logic [3:0]         slot,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [17:0] dir_x,
  input  logic signed [17:0] dir_y,
  input  logic signed [17:0] dir_z,
  input  logic [30:0]        radius,
  output logic               hit,
  output logic [3:0]         sphere_index,
  output logic [30:0]        distance,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [17:0] normal_x,
  output logic signed [17:0] normal_y,
  output logic signed [17:0] normal_z
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_DIFF  = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_MWAIT = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_ROOT  = 4'd7;
  localparam logic [3:0] ST_NEXT  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_LEN   = 4'd10;
  localparam logic [3:0] ST_LWAIT = 4'd11;
  localparam logic [3:0] ST_DIV   = 4'd12;
  localparam logic [3:0] ST_DWAIT = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  localparam logic [3:0] MS_DOT_X = 4'd0;
  localparam logic [3:0] MS_DOT_Y = 4'd1;
  localparam logic [3:0] MS_DOT_Z = 4'd2;
  localparam logic [3:0] MS_SQ_X  = 4'd3;
  localparam logic [3:0] MS_SQ_Y  = 4'd4;
  localparam logic [3:0] MS_SQ_Z  = 4'd5;
  localparam logic [3:0] MS_BB    = 4'd6;
  localparam logic [3:0] MS_RR    = 4'd7;
  localparam logic [3:0] MS_PT_X  = 4'd8;
  localparam logic [3:0] MS_PT_Y  = 4'd9;
  localparam logic [3:0] MS_PT_Z  = 4'd10;
  localparam logic [3:0] MS_VV_X  = 4'd11;
  localparam logic [3:0] MS_VV_Y  = 4'd12;
  localparam logic [3:0] MS_VV_Z  = 4'd13;

  logic [3:0]  state;
  logic [4:0]  sphere_count;
  logic [15:0] min_distance;
  logic        cfg_wr;
  logic [4:0]  n_act;
  logic        accept;

  logic [rsn_pkg::SLOT_W-1:0] idx;
  logic [3:0]                 mstep;
  logic [1:0]                 dk;

  logic signed [31:0] ox, oy, oz;
  logic signed [17:0] ux, uy, uz;
  logic signed [32:0] dx, dy, dz;
  logic signed [53:0] dot;
  logic signed [37:0] b;
  logic [67:0]        dd;
  logic [75:0]        p;

  logic signed [39:0] t0, t1, t_sel, lim, best;
  logic               t0_ok, t1_ok, hit_now;
  logic               found;
  logic [3:0]         bidx;
  logic signed [31:0] bcx, bcy, bcz;

  logic signed [41:0] pxr, pyr, pzr, pt_new;
  logic signed [42:0] vx, vy, vz, v_new;
  logic signed [31:0] o_sel, c_sel;
  logic [87:0]        sq;
  logic [43:0]        len;
  logic signed [17:0] nx, ny, nz, n_new;

  logic [rsn_pkg::ENT_W-1:0] ent;
  logic signed [31:0]        ccx, ccy, ccz;
  logic [30:0]               rr;
  logic                      ram_we;

  logic                        mul_start, mul_done, mneg;
  logic [rsn_pkg::OP_W-1:0]    ma, mb;
  logic [rsn_pkg::PROD_W-1:0]  prod;
  logic signed [88:0]          sprod;

  logic                        sq_start, sq_done;
  logic [rsn_pkg::RAD_W-1:0]   sq_in;
  logic [rsn_pkg::ROOT_W-1:0]  sq_root;

  logic                        div_start, div_done, dneg;
  logic [rsn_pkg::OP_W-1:0]    dnum;
  logic [rsn_pkg::QUO_W-1:0]   quo;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
      min_distance <= rsn_pkg::MIN_DIST_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        rsn_pkg::REG_COUNT: sphere_count <= pwdata[4:0];
        rsn_pkg::REG_MIND:  min_distance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rsn_pkg::REG_COUNT: prdata = {27'd0, sphere_count};
      rsn_pkg::REG_MIND:  prdata = {16'd0, min_distance};
      default:            prdata = '0;
    endcase
  end

  assign n_act  = (sphere_count > 5'(rsn_pkg::MAX_SPHERES)) ?
                  5'(rsn_pkg::MAX_SPHERES) : sphere_count;
  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;
  assign ram_we = accept && (opcode == rsn_pkg::OP_LOAD) &&
                  ({1'b0, slot} < 5'(rsn_pkg::MAX_SPHERES));

  rsn_ram #(.WIDTH(rsn_pkg::ENT_W), .DEPTH(rsn_pkg::MAX_SPHERES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata ({pos_x, pos_y, pos_z, radius}),
    .raddr (idx),
    .rdata (ent)
  );

  assign ccx = ent[126:95];
  assign ccy = ent[94:63];
  assign ccz = ent[62:31];
  assign rr  = ent[30:0];

  assign b   = dot[53:16];
  assign lim = $signed({24'd0, min_distance});

  // operand selection for the shared multiplier
  always_comb begin
    ma   = '0;
    mb   = '0;
    mneg = 1'b0;
    case (mstep)
      MS_DOT_X: begin
        ma = rsn_pkg::mag(44'(dx)); mb = rsn_pkg::mag(44'(ux)); mneg = dx[32] ^ ux[17];
      end
      MS_DOT_Y: begin
        ma = rsn_pkg::mag(44'(dy)); mb = rsn_pkg::mag(44'(uy)); mneg = dy[32] ^ uy[17];
      end
      MS_DOT_Z: begin
        ma = rsn_pkg::mag(44'(dz)); mb = rsn_pkg::mag(44'(uz)); mneg = dz[32] ^ uz[17];
      end
      MS_SQ_X: begin
        ma = rsn_pkg::mag(44'(dx)); mb = ma;
      end
      MS_SQ_Y: begin
        ma = rsn_pkg::mag(44'(dy)); mb = ma;
      end
      MS_SQ_Z: begin
        ma = rsn_pkg::mag(44'(dz)); mb = ma;
      end
      MS_BB: begin
        ma = rsn_pkg::mag(44'(b)); mb = ma;
      end
      MS_RR: begin
        ma = {13'd0, rr}; mb = ma;
      end
      MS_PT_X: begin
        ma = rsn_pkg::mag(44'(ux)); mb = rsn_pkg::mag(44'(best)); mneg = ux[17];
      end
      MS_PT_Y: begin
        ma = rsn_pkg::mag(44'(uy)); mb = rsn_pkg::mag(44'(best)); mneg = uy[17];
      end
      MS_PT_Z: begin
        ma = rsn_pkg::mag(44'(uz)); mb = rsn_pkg::mag(44'(best)); mneg = uz[17];
      end
      MS_VV_X: begin
        ma = rsn_pkg::mag(44'(vx)); mb = ma;
      end
      MS_VV_Y: begin
        ma = rsn_pkg::mag(44'(vy)); mb = ma;
      end
      MS_VV_Z: begin
        ma = rsn_pkg::mag(44'(vz)); mb = ma;
      end
      default: ;
    endcase
  end

  assign sprod = mneg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

  always_comb begin
    case (mstep)
      MS_PT_X: begin o_sel = ox; c_sel = bcx; end
      MS_PT_Y: begin o_sel = oy; c_sel = bcy; end
      default: begin o_sel = oz; c_sel = bcz; end
    endcase
  end

  assign pt_new = 42'(o_sel) + 42'(sprod >>> 16);
  assign v_new  = 43'(pt_new) - 43'(c_sel);

  assign t0      = -40'(b) - $signed({1'b0, sq_root[38:0]});
  assign t1      = -40'(b) + $signed({1'b0, sq_root[38:0]});
  assign t0_ok   = t0 > lim;
  assign t1_ok   = t1 > lim;
  assign hit_now = t0_ok | t1_ok;
  assign t_sel   = t0_ok ? t0 : t1;

  assign mul_start = (state == ST_MUL);
  assign sq_start  = (state == ST_LEN) || ((state == ST_CMP) && (76'(dd) <= p));
  assign sq_in     = (state == ST_LEN) ? sq : 88'(p - 76'(dd));
  assign div_start = (state == ST_DIV);

  always_comb begin
    case (dk)
      2'd0:    begin dnum = rsn_pkg::mag(44'(vx)); dneg = vx[42]; end
      2'd1:    begin dnum = rsn_pkg::mag(44'(vy)); dneg = vy[42]; end
      default: begin dnum = rsn_pkg::mag(44'(vz)); dneg = vz[42]; end
    endcase
  end

  assign n_new = dneg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  rsn_mul u_mul (
    .clk (clk), .rst (rst), .start (mul_start), .a (ma), .b (mb),
    .done (mul_done), .prod (prod)
  );

  rsn_sqrt u_sqrt (
    .clk (clk), .rst (rst), .start (sq_start), .rad (sq_in),
    .done (sq_done), .root (sq_root)
  );

  rsn_div u_div (
    .clk (clk), .rst (rst), .start (div_start), .num (dnum), .den (len),
    .done (div_done), .quo (quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
      idx   <= '0;
      mstep <= '0;
      dk    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (opcode == rsn_pkg::OP_CAST)) begin
            ox    <= pos_x;
            oy    <= pos_y;
            oz    <= pos_z;
            ux    <= dir_x;
            uy    <= dir_y;
            uz    <= dir_z;
            idx   <= '0;
            found <= 1'b0;
            best  <= '0;
            bidx  <= '0;
            state <= (n_act == '0) ? ST_FIN : ST_RD;
          end
        end
        ST_RD: state <= ST_DIFF;
        ST_DIFF: begin
          dx    <= 33'(ox) - 33'(ccx);
          dy    <= 33'(oy) - 33'(ccy);
          dz    <= 33'(oz) - 33'(ccz);
          dot   <= '0;
          dd    <= '0;
          mstep <= MS_DOT_X;
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            case (mstep)
              MS_DOT_X, MS_DOT_Y, MS_DOT_Z: dot <= dot + 54'(sprod);
              MS_SQ_X, MS_SQ_Y, MS_SQ_Z:    dd  <= dd + 68'(prod);
              MS_BB:                        p   <= 76'(prod);
              MS_RR:                        p   <= p + 76'(prod);
              MS_PT_X: begin pxr <= pt_new; vx <= v_new; end
              MS_PT_Y: begin pyr <= pt_new; vy <= v_new; end
              MS_PT_Z: begin pzr <= pt_new; vz <= v_new; end
              default:                      sq  <= sq + prod;
            endcase
            if (mstep == MS_RR) begin
              state <= ST_CMP;
            end else if (mstep == MS_VV_Z) begin
              state <= ST_LEN;
            end else begin
              mstep <= mstep + 1'b1;
              state <= ST_MUL;
            end
          end
        end
        ST_CMP: state <= (76'(dd) > p) ? ST_NEXT : ST_SQ;
        ST_SQ: begin
          if (sq_done) state <= ST_ROOT;
        end
        ST_ROOT: begin
          // keep only a strictly closer hit, so the lower slot wins a tie
          if (hit_now && (!found || (t_sel < best))) begin
            found <= 1'b1;
            best  <= t_sel;
            bidx  <= idx;
            bcx   <= ccx;
            bcy   <= ccy;
            bcz   <= ccz;
          end
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (({1'b0, idx} + 5'd1) == n_act) begin
            state <= ST_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_RD;
          end
        end
        ST_FIN: begin
          nx    <= '0;
          ny    <= '0;
          nz    <= '0;
          sq    <= '0;
          mstep <= MS_PT_X;
          state <= found ? ST_MUL : ST_OUT;
        end
        ST_LEN: state <= ST_LWAIT;
        ST_LWAIT: begin
          if (sq_done) begin
            len   <= sq_root;
            dk    <= '0;
            state <= (sq_root == '0) ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: state <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            case (dk)
              2'd0:    nx <= n_new;
              2'd1:    ny <= n_new;
              default: nz <= n_new;
            endcase
            if (dk == 2'd2) begin
              state <= ST_OUT;
            end else begin
              dk    <= dk + 1'b1;
              state <= ST_DIV;
            end
          end
        end
        ST_OUT: begin
          done         <= 1'b1;
          hit          <= found;
          sphere_index <= found ? bidx : '0;
          distance     <= !found ? '0 :
                          (best > 40'sd2147483647) ? 31'h7FFFFFFF : best[30:0];
          point_x      <= found ? rsn_pkg::sat32(pxr) : '0;
          point_y      <= found ? rsn_pkg::sat32(pyr) : '0;
          point_z      <= found ? rsn_pkg::sat32(pzr) : '0;
          normal_x     <= found ? nx : '0;
          normal_y     <= found ? ny : '0;
          normal_z     <= found ? nz : '0;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (distance == '0 && sphere_index == '0 && point_x == '0))
    else $error("miss result not zero");

  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == rsn_pkg::OP_CAST) |=> busy)
    else $error("cast transfer did not raise busy");

  a_hit_beyond: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> (distance > 31'(min_distance)))
    else $error("hit distance not beyond minimum");

endmodule

// ===== test/tb_ray_sphere_nearest_hit_core.sv =====
// Testbench for the ray against sphere table nearest-hit core.
`timescale 1ns / 1ps

module tb_ray_sphere_nearest_hit_core;

  localparam longint UNIT      = 65536;
  localparam int     QUIET_MAX = 20000;
  localparam int     N_ITEMS   = 1000;

  typedef struct {
    bit               opcode;
    bit [3:0]         slot;
    bit signed [31:0] px, py, pz;
    bit signed [17:0] dx, dy, dz;
    bit [30:0]        rad;
  } cmd_t;

  typedef struct {
    bit        hit;
    bit [3:0]  idx;
    bit [30:0] dval;
    bit [31:0] px, py, pz;
    bit [17:0] nx, ny, nz;
  } hit_rec_t;

  class hit_scoreboard;
    longint   cen_x[rsn_pkg::MAX_SPHERES], cen_y[rsn_pkg::MAX_SPHERES];
    longint   cen_z[rsn_pkg::MAX_SPHERES];
    longint   rad_tab[rsn_pkg::MAX_SPHERES];
    int       active_count;
    longint   min_dist;
    hit_rec_t hits_due[$];
    int       errors, casts, hits, loads;

    function void set_reg(bit idx, bit [31:0] v);
      if (idx == rsn_pkg::REG_COUNT) active_count = int'(v[4:0]);
      else min_dist = longint'(v[15:0]);
    endfunction

    function bit [63:0] root_floor(bit [127:0] n);
      bit [63:0]  res, c;
      bit [127:0] cc;
      res = 0;
      for (int k = 43; k >= 0; k--) begin
        c = res | (64'd1 << k);
        cc = {64'd0, c} * {64'd0, c};
        if (cc <= n) res = c;
      end
      return res;
    endfunction

    // nearest positive root above the limit, or 0 when the sphere is missed
    function bit sphere_root(int i, longint o[3], longint u[3], output longint t);
      logic signed [127:0] dw[3], bw, rw, disc;
      longint d[3], b, s;
      d[0] = o[0] - cen_x[i];
      d[1] = o[1] - cen_y[i];
      d[2] = o[2] - cen_z[i];
      b = (d[0] * u[0] + d[1] * u[1] + d[2] * u[2]) >>> 16;
      for (int k = 0; k < 3; k++) dw[k] = d[k];
      bw = b;
      rw = rad_tab[i];
      disc = bw * bw + rw * rw - (dw[0] * dw[0] + dw[1] * dw[1] + dw[2] * dw[2]);
      t = 0;
      if (disc < 0) return 0;
      s = longint'(root_floor(disc));
      if (-b - s > min_dist) begin t = -b - s; return 1; end
      if (-b + s > min_dist) begin t = -b + s; return 1; end
      return 0;
    endfunction

    function void note(cmd_t c);
      hit_rec_t            r;
      longint              o[3], u[3], cen[3], v[3], pt, t, best, len;
      logic signed [127:0] vw, sq;
      int                  n, bi;
      bit                  found;
      o[0] = c.px; o[1] = c.py; o[2] = c.pz;
      if (c.opcode == rsn_pkg::OP_LOAD) begin
        cen_x[c.slot] = o[0]; cen_y[c.slot] = o[1]; cen_z[c.slot] = o[2];
        rad_tab[c.slot] = c.rad;
        loads++;
        return;
      end
      u[0] = c.dx; u[1] = c.dy; u[2] = c.dz;
      n = active_count > rsn_pkg::MAX_SPHERES ? rsn_pkg::MAX_SPHERES : active_count;
      found = 0; best = 0; bi = 0;
      for (int i = 0; i < n; i++)
        if (sphere_root(i, o, u, t) && (!found || t < best)) begin
          found = 1; best = t; bi = i;
        end
      r = '{default: 0};
      casts++;
      if (found) begin
        hits++;
        cen[0] = cen_x[bi]; cen[1] = cen_y[bi]; cen[2] = cen_z[bi];
        r.hit = 1;
        r.idx = 4'(bi);
        r.dval = best > 64'sd2147483647 ? 31'h7FFFFFFF : best[30:0];
        sq = 0;
        for (int k = 0; k < 3; k++) begin
          pt = o[k] + ((u[k] * best) >>> 16);
          v[k] = pt - cen[k];
          vw = v[k];
          sq += vw * vw;
          if (pt > 64'sd2147483647) pt = 64'sd2147483647;
          if (pt < -64'sd2147483648) pt = -64'sd2147483648;
          if (k == 0) r.px = pt[31:0];
          else if (k == 1) r.py = pt[31:0];
          else r.pz = pt[31:0];
        end
        len = longint'(root_floor(sq));
        if (len != 0) begin
          r.nx = 18'((v[0] * 65536) / len);
          r.ny = 18'((v[1] * 65536) / len);
          r.nz = 18'((v[2] * 65536) / len);
        end
      end
      hits_due.push_back(r);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
      errors++;
    endtask

    task check(hit_rec_t a);
      hit_rec_t e;
      if (hits_due.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      e = hits_due.pop_front();
      if (a.hit  != e.hit)  report("hit", a.hit, e.hit);
      if (a.idx  != e.idx)  report("sphere_index", a.idx, e.idx);
      if (a.dval != e.dval) report("distance", a.dval, e.dval);
      if (a.px   != e.px)   report("point_x", a.px, e.px);
      if (a.py   != e.py)   report("point_y", a.py, e.py);
      if (a.pz   != e.pz)   report("point_z", a.pz, e.pz);
      if (a.nx   != e.nx)   report("normal_x", a.nx, e.nx);
      if (a.ny   != e.ny)   report("normal_y", a.ny, e.ny);
      if (a.nz   != e.nz)   report("normal_z", a.nz, e.nz);
    endtask
  endclass

  logic               clk = 0, rst = 1;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0, prdata;
  logic               pready, start = 0, busy, done;
  logic               opcode = 0;
  logic [3:0]         slot = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
  logic signed [17:0] dir_x = 0, dir_y = 0, dir_z = 0;
  logic [30:0]        radius = 0;
  logic               hit;
  logic [3:0]         sphere_index;
  logic [30:0]        distance;
  logic signed [31:0] point_x, point_y, point_z;
  logic signed [17:0] normal_x, normal_y, normal_z;

  hit_scoreboard sb = new();
  int            quiet = 0;
  bit            allow_idle = 1;

  ray_sphere_nearest_hit_core u_dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (done)
      sb.check('{hit, sphere_index, distance, point_x, point_y, point_z,
                 normal_x, normal_y, normal_z});
    if ((start && !busy) || done || psel || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_MAX) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_MAX);
      $display("Regression FAIL");
      $finish;
    end
  end

  // entered and left just after a falling edge
  task automatic send(cmd_t c);
    if (allow_idle && $urandom_range(3) == 0) begin
      start = 0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    opcode = c.opcode; slot = c.slot; radius = c.rad;
    pos_x = c.px; pos_y = c.py; pos_z = c.pz;
    dir_x = c.dx; dir_y = c.dy; dir_z = c.dz;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note(c);
    @(negedge clk);
  endtask

  task automatic settle();
    start = 0;
    while (sb.hits_due.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bit idx, bit [31:0] v);
    settle();
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    sb.set_reg(idx, v);
  endtask

  function automatic cmd_t load_cmd(int s, longint x, longint y, longint z, longint r);
    cmd_t c;
    c = '{default: 0};
    c.opcode = rsn_pkg::OP_LOAD; c.slot = 4'(s);
    c.px = 32'(x); c.py = 32'(y); c.pz = 32'(z); c.rad = 31'(r);
    return c;
  endfunction

  function automatic cmd_t cast_cmd(longint x, longint y, longint z,
                                    longint ux, longint uy, longint uz);
    cmd_t c;
    c = '{default: 0};
    c.opcode = rsn_pkg::OP_CAST; c.px = 32'(x); c.py = 32'(y); c.pz = 32'(z);
    c.dx = 18'(ux); c.dy = 18'(uy); c.dz = 18'(uz);
    c.slot = 4'($urandom); c.rad = 31'($urandom);
    return c;
  endfunction

  function automatic longint span(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  // cast aimed near a target point, with a unit direction
  function automatic cmd_t aimed_cast(longint tx, longint ty, longint tz);
    longint o[3];
    real    vx, vy, vz, l;
    for (int k = 0; k < 3; k++) o[k] = span(-30, 30) * UNIT + span(-UNIT, UNIT);
    vx = real'(tx - o[0]) + real'(span(-2, 2) * UNIT);
    vy = real'(ty - o[1]) + real'(span(-2, 2) * UNIT);
    vz = real'(tz - o[2]) + real'(span(-2, 2) * UNIT);
    l = $sqrt(vx * vx + vy * vy + vz * vz);
    if (l == 0.0) return cast_cmd(o[0], o[1], o[2], UNIT, 0, 0);
    return cast_cmd(o[0], o[1], o[2], $rtoi(vx / l * 65536.0),
                    $rtoi(vy / l * 65536.0), $rtoi(vz / l * 65536.0));
  endfunction

  function automatic cmd_t scene_load();
    return load_cmd($urandom_range(15), span(-20, 20) * UNIT + span(0, UNIT),
                    span(-20, 20) * UNIT, span(-20, 20) * UNIT + span(0, UNIT),
                    span(UNIT / 4, 8 * UNIT));
  endfunction

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.opcode = 1'($urandom); c.slot = 4'($urandom);
    c.px = $urandom; c.py = $urandom; c.pz = $urandom;
    c.dx = 18'(span(-UNIT, UNIT)); c.dy = 18'(span(-UNIT, UNIT));
    c.dz = 18'(span(-UNIT, UNIT));
    c.rad = 31'($urandom);
    return c;
  endfunction

  initial begin
    int r, sel;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // empty table: every cast misses
    write_reg(rsn_pkg::REG_COUNT, 0);
    send(cast_cmd(0, 0, 0, UNIT, 0, 0));
    for (int i = 0; i < 16; i++)
      send(load_cmd(i, (4 * i - 30) * UNIT, 0, 10 * UNIT, UNIT));
    // twin of slot 2 further up the table: the lower slot wins the tie
    send(load_cmd(9, -22 * UNIT, 0, 10 * UNIT, UNIT));
    send(load_cmd(12, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0));
    write_reg(rsn_pkg::REG_COUNT, 16);
    write_reg(rsn_pkg::REG_MIND, 0);
    send(cast_cmd(-22 * UNIT, 0, -20 * UNIT, 0, 0, UNIT));
    send(cast_cmd(-22 * UNIT, 0, 10 * UNIT, 0, 0, -UNIT));
    send(cast_cmd(-22 * UNIT, 0, 10 * UNIT, -UNIT, 0, 0));
    send(cast_cmd(0, 50 * UNIT, 0, 0, UNIT, 0));
    send(cast_cmd(5 * UNIT, 5 * UNIT, -3 * UNIT, 0, 0, UNIT));
    send(cast_cmd(-30 * UNIT, 0, 0, UNIT, UNIT, UNIT));
    send(cast_cmd(-26 * UNIT, -20 * UNIT, 10 * UNIT, 0, UNIT, 0));
    // far origin and far sphere: saturated distance and point
    send(load_cmd(15, 32767 * UNIT, 0, 0, 10 * UNIT));
    send(cast_cmd(-32767 * UNIT, 0, 0, UNIT, 0, 0));
    send(load_cmd(14, -32'sd2147483648, 32'sd2147483647, 0, 31'h7FFFFFFF));
    send(cast_cmd(-32'sd2147483648, -32'sd2147483648, 32'sd2147483647, -UNIT, UNIT, -UNIT));
    send(cast_cmd(32'sd2147483647, 0, 0, -UNIT, -UNIT, UNIT));
    write_reg(rsn_pkg::REG_MIND, 65535);
    send(cast_cmd(-22 * UNIT, 0, 9 * UNIT, 0, 0, UNIT));
    write_reg(rsn_pkg::REG_COUNT, 31);
    send(cast_cmd(2 * UNIT, 0, -20 * UNIT, 0, 0, UNIT));

    for (int ph = 0; ph < 10; ph++) begin
      sel = $urandom_range(5);
      write_reg(rsn_pkg::REG_COUNT, sel == 0 ? 0 : sel == 1 ? 1 : sel == 2 ? 16 :
                           sel == 3 ? $urandom_range(31, 17) : $urandom_range(8, 2));
      sel = $urandom_range(3);
      write_reg(rsn_pkg::REG_MIND, sel == 0 ? 0 : sel == 1 ? 66 : sel == 2 ? 65535 :
                          $urandom_range(65535));
      for (int i = 0; i < N_ITEMS / 10; i++) begin
        allow_idle = !(ph == 9 && i > 40);
        r = $urandom_range(99);
        if (r < 55) begin
          sel = $urandom_range(15);
          send(aimed_cast(sb.cen_x[sel], sb.cen_y[sel], sb.cen_z[sel]));
        end
        else if (r < 80) send(scene_load());
        else send(noise_cmd());
      end
    end

    settle();
    repeat (200) @(negedge clk);
    $display("covered %0d loads and %0d casts, %0d of them hits, over ten register settings",
             sb.loads, sb.casts, sb.hits);
    if (sb.errors == 0 && sb.hits_due.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rsn_pkg.sv
rtl/rsn_ram.sv
rtl/rsn_mul.sv
rtl/rsn_sqrt.sv
rtl/rsn_div.sv
rtl/ray_sphere_nearest_hit_core.sv
test/tb_ray_sphere_nearest_hit_core.sv
